// ===== design/rect_pkg.sv =====
`default_nettype none

package rect_pkg;

    // Key store and round schedule
    localparam int unsigned KEY_SLOTS   = 26;
    localparam int unsigned DEC_ROUNDS  = 25;
    localparam int unsigned KEY_IDX_W   = 5;
    localparam int unsigned BLOCK_W     = 64;
    localparam int unsigned ROW_W       = 16;

    // Inverse row rotation amounts (rotate right)
    localparam int unsigned ROT_ROW1    = 1;
    localparam int unsigned ROT_ROW2    = 12;
    localparam int unsigned ROT_ROW3    = 13;

    typedef enum logic {
        OP_LOAD_KEY = 1'b0,
        OP_DECRYPT  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_FINAL
    } core_state_t;

    // One queued word: a key load or a block to decrypt
    typedef struct packed {
        logic                  is_block;
        logic [KEY_IDX_W-1:0]  key_index;
        logic [BLOCK_W-1:0]    data;
    } cmd_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // Back-end status
    typedef struct packed {
        logic busy;
        logic pop;
    } core_stat_t;

    function automatic logic [ROW_W-1:0] rotr16(input logic [ROW_W-1:0] x,
                                                input int unsigned n);
        rotr16 = (x >> n) | (x << (ROW_W - n));
    endfunction

    // One inverse round: inverse row rotations, then bitsliced inverse S-box
    function automatic logic [BLOCK_W-1:0] inv_round(input logic [BLOCK_W-1:0] s);
        logic [ROW_W-1:0] a0, a1, a2, a3;
        logic [ROW_W-1:0] t0, t1, t2, t3, t4, t5;
        logic [ROW_W-1:0] b0, b1, b2, b3;
        a0 = s[15:0];
        a1 = rotr16(s[31:16], ROT_ROW1);
        a2 = rotr16(s[47:32], ROT_ROW2);
        a3 = rotr16(s[63:48], ROT_ROW3);
        t2 = a0 ^ a1;
        t0 = (a0 | a3) ^ a2;
        b2 = a1 ^ t0;
        t1 = (a0 & t0) ^ a3;
        b1 = t1 ^ b2;
        t3 = ~b1;
        t4 = t0 | t3;
        b3 = t4 ^ t2;
        t5 = b3 | t3;
        b0 = t0 ^ t5;
        inv_round = {b3, b2, b1, b0};
    endfunction

endpackage

`default_nettype wire

// ===== design/rect_queue.sv =====
`default_nettype none

module rect_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire rect_pkg::cmd_t     push_word,
    input  wire logic               pop,
    output rect_pkg::cmd_t          head_word,
    output rect_pkg::queue_stat_t   stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rect_pkg::cmd_t      slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_word  = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap, track fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

// ===== design/rect_front.sv =====
`default_nettype none

module rect_front #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_operation,
    input  wire logic [rect_pkg::KEY_IDX_W-1:0]     s_key_index,
    input  wire logic [rect_pkg::BLOCK_W-1:0]       s_data_word,
    input  wire logic                               pop,
    output rect_pkg::cmd_t                          head_word,
    output rect_pkg::queue_stat_t                   stat,
    output logic                                    push
);

    rect_pkg::cmd_t  cmd;
    logic            is_block;
    logic            slot_ok;

    // Classify the incoming word; drop loads aimed past the key store
    assign is_block      = (rect_pkg::op_t'(s_operation) == rect_pkg::OP_DECRYPT);
    assign slot_ok       = (s_key_index < rect_pkg::KEY_IDX_W'(rect_pkg::KEY_SLOTS));
    assign cmd.is_block  = is_block;
    assign cmd.key_index = s_key_index;
    assign cmd.data      = s_data_word;

    assign s_ready = !stat.full;
    assign push    = s_valid && s_ready && (is_block || slot_ok);

    rect_queue #(
        .DEPTH     (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_word (cmd),
        .pop       (pop),
        .head_word (head_word),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// ===== design/rect_core.sv =====
`default_nettype none

module rect_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire rect_pkg::cmd_t                     head_word,
    input  wire rect_pkg::queue_stat_t              q_stat,
    output rect_pkg::core_stat_t                    stat,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [rect_pkg::BLOCK_W-1:0]            m_plain_block
);

    localparam int unsigned RND_W = rect_pkg::KEY_IDX_W;

    rect_pkg::core_state_t              state_reg, state_next;
    logic [RND_W-1:0]                   round_reg, round_next;
    logic [rect_pkg::BLOCK_W-1:0]       blk_reg, blk_next;
    logic [rect_pkg::BLOCK_W-1:0]       out_reg, out_next;
    logic                               out_valid_reg, out_valid_next;

    logic [rect_pkg::BLOCK_W-1:0]       key_mem [rect_pkg::KEY_SLOTS];
    logic [rect_pkg::BLOCK_W-1:0]       key_q;
    logic [RND_W-1:0]                   rd_addr;
    logic                               key_wr;
    logic                               pop;

    assign m_valid       = out_valid_reg;
    assign m_plain_block = out_reg;
    assign stat.busy     = (state_reg != rect_pkg::CORE_IDLE);
    assign stat.pop      = pop;

    // Sequence: pop, 25 inverse rounds, final key add into the output register
    always_comb begin
        state_next     = state_reg;
        round_next     = round_reg;
        blk_next       = blk_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        rd_addr        = RND_W'(rect_pkg::DEC_ROUNDS);
        key_wr         = 1'b0;
        pop            = 1'b0;
        case (state_reg)
            rect_pkg::CORE_IDLE: begin
                if (!q_stat.empty) begin
                    pop = 1'b1;
                    if (head_word.is_block) begin
                        blk_next   = head_word.data;
                        round_next = RND_W'(rect_pkg::DEC_ROUNDS);
                        state_next = rect_pkg::CORE_ROUND;
                    end else begin
                        key_wr = 1'b1;
                    end
                end
            end
            rect_pkg::CORE_ROUND: begin
                rd_addr    = round_reg - 1'b1;
                blk_next   = rect_pkg::inv_round(blk_reg ^ key_q);
                round_next = round_reg - 1'b1;
                if (round_reg == RND_W'(1)) begin
                    state_next = rect_pkg::CORE_FINAL;
                end
            end
            rect_pkg::CORE_FINAL: begin
                // hold key 0 on the read port while the output is blocked
                rd_addr = '0;
                if (!out_valid_reg || m_ready) begin
                    out_next       = blk_reg ^ key_q;
                    out_valid_next = 1'b1;
                    state_next     = rect_pkg::CORE_IDLE;
                end
            end
            default: begin
                state_next = rect_pkg::CORE_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rect_pkg::CORE_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        round_reg <= round_next;
        blk_reg   <= blk_next;
        out_reg   <= out_next;
    end

    // Round key store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (key_wr) begin
            key_mem[head_word.key_index] <= head_word.data;
        end
        key_q <= key_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/rectangle64_block_decrypt.sv =====
`default_nettype none

// Channel  Direction  Ports                                         Word
// s_       in         s_valid s_ready s_operation s_key_index       key load or ciphertext
//                     s_data_word
// m_       out        m_valid m_ready m_plain_block                 plaintext block
//
// A key load is written into the key store when the back end pops it from the queue.
// A block leaves the queue, then passes 25 inverse rounds through the single round
// unit (one per cycle) and one final key add into the output register.
// The round key store has one registered read port, read one key per round.
// Reset (aresetn, synchronous) empties the queue and clears the output valid;
// the key store holds nothing until written.
// s_ready drops only while the queue is full; a stalled result holds the back
// end in its final step while the front keeps accepting.

module rectangle64_block_decrypt #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_operation,
    input  wire logic [rect_pkg::KEY_IDX_W-1:0]     s_key_index,
    input  wire logic [rect_pkg::BLOCK_W-1:0]       s_data_word,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [rect_pkg::BLOCK_W-1:0]            m_plain_block
);

    rect_pkg::cmd_t         head_word;
    rect_pkg::queue_stat_t  q_stat;
    rect_pkg::core_stat_t   c_stat;
    logic                   push;

    rect_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_key_index (s_key_index),
        .s_data_word (s_data_word),
        .pop         (c_stat.pop),
        .head_word   (head_word),
        .stat        (q_stat),
        .push        (push)
    );

    rect_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_word     (head_word),
        .q_stat        (q_stat),
        .stat          (c_stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_plain_block (m_plain_block)
    );

`ifndef NO_ASSERTIONS
    // Out-of-range key loads never reach the queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_operation == rect_pkg::OP_LOAD_KEY &&
         s_key_index >= rect_pkg::KEY_IDX_W'(rect_pkg::KEY_SLOTS)) |-> !push)
        else $error("out-of-range key load pushed");

    // The back end takes a word only when idle and the queue holds one
    assert property (@(posedge aclk) disable iff (!aresetn)
        c_stat.pop |-> (!c_stat.busy && !q_stat.empty))
        else $error("queue popped while busy or empty");

    // A block pop starts a decrypt on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (c_stat.pop && head_word.is_block) |=> c_stat.busy)
        else $error("block popped without starting rounds");
`endif

endmodule

`default_nettype wire
